// File: hdl/rrlp_pkg.sv
// Shared types and codes for the report line parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrlp_pkg;

    // Longest line, in bytes before the newline, that can still pass
    localparam int LINE_MAX = 64;
    localparam int LEN_W    = $clog2(LINE_MAX + 2);

    // Line end character
    localparam logic [7:0] CHAR_NL = 8'd10;

    // Result status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_PREFIX    = 4'd1;
    localparam logic [3:0] ST_NO_CPS    = 4'd2;
    localparam logic [3:0] ST_CPM_LABEL = 4'd3;
    localparam logic [3:0] ST_NO_CPM    = 4'd4;
    localparam logic [3:0] ST_DOSE_LBL  = 4'd5;
    localparam logic [3:0] ST_NO_DOSE   = 4'd6;
    localparam logic [3:0] ST_TAIL      = 4'd7;
    localparam logic [3:0] ST_OVERFLOW  = 4'd8;

    // One parsed line
    typedef struct packed {
        logic signed [31:0] dose_milli;
        logic signed [31:0] cpm_value;
        logic signed [31:0] cps_value;
        logic        [3:0]  status;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/rrlp_in_stage.sv
// Input register of the report line parser: holds one received byte.
// Depends on rrlp_pkg.
`default_nettype none

module rrlp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    input  wire logic       i_take
);
    import rrlp_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    // Accept a beat whenever the held byte is empty or leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: hdl/rrlp_parser.sv
// Per-byte line parser: literal matching, number accumulation, error latch.
// Depends on rrlp_pkg.
`default_nettype none

module rrlp_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_byte_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_room,
    output logic             o_take,
    output logic             o_res_valid,
    output rrlp_pkg::t_result o_res
);
    import rrlp_pkg::*;

    // Parse phases
    localparam logic [3:0] PH_PREFIX    = 4'd0;
    localparam logic [3:0] PH_CPS_LEAD  = 4'd1;
    localparam logic [3:0] PH_CPS_NUM   = 4'd2;
    localparam logic [3:0] PH_CPM_LIT   = 4'd3;
    localparam logic [3:0] PH_CPM_LEAD  = 4'd4;
    localparam logic [3:0] PH_CPM_NUM   = 4'd5;
    localparam logic [3:0] PH_DOSE_LIT  = 4'd6;
    localparam logic [3:0] PH_DOSE_LEAD = 4'd7;
    localparam logic [3:0] PH_DOSE_INT  = 4'd8;
    localparam logic [3:0] PH_DOSE_FRAC = 4'd9;
    localparam logic [3:0] PH_TAIL_LIT  = 4'd10;
    localparam logic [3:0] PH_MODE      = 4'd11;
    localparam logic [3:0] PH_SKIP      = 4'd12;

    // Literal identifiers
    localparam logic [1:0] LIT_PREFIX = 2'd0;
    localparam logic [1:0] LIT_CPM    = 2'd1;
    localparam logic [1:0] LIT_DOSE   = 2'd2;
    localparam logic [1:0] LIT_TAIL   = 2'd3;

    localparam logic [31:0] MAG_MAX = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Character of a literal at a position
    function automatic logic [7:0] lit_char(input logic [1:0] id, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        case (id)
            LIT_PREFIX: begin
                case (pos)
                    4'd0:    ch = "C";
                    4'd1:    ch = "P";
                    4'd2:    ch = "S";
                    4'd3:    ch = ",";
                    4'd4:    ch = " ";
                    default: ch = 8'd0;
                endcase
            end
            LIT_CPM: begin
                case (pos)
                    4'd0:    ch = ",";
                    4'd1:    ch = " ";
                    4'd2:    ch = "C";
                    4'd3:    ch = "P";
                    4'd4:    ch = "M";
                    4'd5:    ch = ",";
                    4'd6:    ch = " ";
                    default: ch = 8'd0;
                endcase
            end
            LIT_DOSE: begin
                case (pos)
                    4'd0:    ch = ",";
                    4'd1:    ch = " ";
                    4'd2:    ch = "u";
                    4'd3:    ch = "S";
                    4'd4:    ch = "v";
                    4'd5:    ch = "/";
                    4'd6:    ch = "h";
                    4'd7:    ch = "r";
                    4'd8:    ch = ",";
                    4'd9:    ch = " ";
                    default: ch = 8'd0;
                endcase
            end
            default: begin
                case (pos)
                    4'd0:    ch = ",";
                    4'd1:    ch = " ";
                    default: ch = 8'd0;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] lit_len(input logic [1:0] id);
        logic [3:0] len;
        case (id)
            LIT_PREFIX: len = 4'd5;
            LIT_CPM:    len = 4'd7;
            LIT_DOSE:   len = 4'd10;
            default:    len = 4'd2;
        endcase
        return len;
    endfunction

    // Magnitude plus sign to two's complement, saturated
    function automatic logic [31:0] to_signed(input logic [31:0] mag, input logic neg);
        logic [31:0] v;
        if (neg) begin
            v = 32'd0 - mag;
        end else begin
            v = (mag > POS_MAX) ? POS_MAX : mag;
        end
        return v;
    endfunction

    logic [3:0]       r_phase, n_phase;
    logic [3:0]       r_pos, n_pos;
    logic             r_digit, n_digit;
    logic             r_neg, n_neg;
    logic [1:0]       r_frac, n_frac;
    logic [31:0]      r_cps, n_cps;
    logic [31:0]      r_cpm, n_cpm;
    logic [31:0]      r_dose, n_dose;
    logic [3:0]       r_err, n_err;
    logic [LEN_W-1:0] r_len, n_len;

    logic             w_step;
    logic             w_space;
    logic             w_is_digit;
    logic             w_sign;
    logic [3:0]       w_dval;
    logic [1:0]       w_lit_id;
    logic [3:0]       w_pos_eff;
    logic             w_hit;
    logic             w_done;
    logic [3:0]       w_code;
    logic [3:0]       w_next;
    logic             w_do_match;
    logic [31:0]      w_acc_cur;
    logic [35:0]      w_acc_x10;
    logic [31:0]      w_acc_dig;
    logic [31:0]      w_acc_end;
    logic [9:0]       w_scale;
    logic [41:0]      w_dose_prod;
    logic [31:0]      w_dose_end;
    logic [3:0]       w_end_st;

    assign o_take = i_byte_valid && ((i_byte != CHAR_NL) || i_room);
    assign w_step = o_take;

    // Classify the byte
    assign w_space    = i_byte inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
    assign w_is_digit = i_byte inside {["0":"9"]};
    assign w_sign     = i_byte inside {"+", "-"};
    assign w_dval     = 4'(i_byte - "0");

    // Pick the literal that this phase compares against
    always_comb begin
        case (r_phase)
            PH_PREFIX:                   w_lit_id = LIT_PREFIX;
            PH_CPS_NUM, PH_CPM_LIT:      w_lit_id = LIT_CPM;
            PH_CPM_NUM, PH_DOSE_LIT:     w_lit_id = LIT_DOSE;
            default:                     w_lit_id = LIT_TAIL;
        endcase
        case (w_lit_id)
            LIT_PREFIX: begin w_code = ST_PREFIX;    w_next = PH_CPS_LEAD;  end
            LIT_CPM:    begin w_code = ST_CPM_LABEL; w_next = PH_CPM_LEAD;  end
            LIT_DOSE:   begin w_code = ST_DOSE_LBL;  w_next = PH_DOSE_LEAD; end
            default:    begin w_code = ST_TAIL;      w_next = PH_MODE;      end
        endcase
    end

    // A literal entered from a number starts at its first character
    assign w_pos_eff = (r_phase == PH_CPS_NUM || r_phase == PH_CPM_NUM
                     || r_phase == PH_DOSE_INT || r_phase == PH_DOSE_FRAC) ? 4'd0 : r_pos;
    assign w_hit  = (w_pos_eff < lit_len(w_lit_id)) && (i_byte == lit_char(w_lit_id, w_pos_eff));
    assign w_done = w_hit && ((w_pos_eff + 4'd1) == lit_len(w_lit_id));

    // Accumulator of the current number: times ten plus digit, saturated
    always_comb begin
        case (r_phase)
            PH_CPS_LEAD, PH_CPS_NUM: w_acc_cur = r_cps;
            PH_CPM_LEAD, PH_CPM_NUM: w_acc_cur = r_cpm;
            default:                 w_acc_cur = r_dose;
        endcase
    end
    assign w_acc_x10 = {1'b0, w_acc_cur, 3'b000} + {3'b000, w_acc_cur, 1'b0}
                     + {32'd0, w_dval};
    assign w_acc_dig = (w_acc_x10 > {4'd0, MAG_MAX}) ? MAG_MAX : w_acc_x10[31:0];
    assign w_acc_end = to_signed(w_acc_cur, r_neg);

    // Scale the dose to thousandths for the fraction digits still missing
    always_comb begin
        case (r_frac)
            2'd0:    w_scale = 10'd1000;
            2'd1:    w_scale = 10'd100;
            2'd2:    w_scale = 10'd10;
            default: w_scale = 10'd1;
        endcase
    end
    assign w_dose_prod = 42'(r_dose) * 42'(w_scale);
    assign w_dose_end  = to_signed((w_dose_prod > {10'd0, MAG_MAX}) ? MAG_MAX
                                   : w_dose_prod[31:0], r_neg);

    // Status for a line that ends now
    always_comb begin
        case (r_phase)
            PH_PREFIX:                   w_end_st = ST_PREFIX;
            PH_CPS_LEAD:                 w_end_st = ST_NO_CPS;
            PH_CPS_NUM:                  w_end_st = r_digit ? ST_CPM_LABEL : ST_NO_CPS;
            PH_CPM_LIT:                  w_end_st = ST_CPM_LABEL;
            PH_CPM_LEAD:                 w_end_st = ST_NO_CPM;
            PH_CPM_NUM:                  w_end_st = r_digit ? ST_DOSE_LBL : ST_NO_CPM;
            PH_DOSE_LIT:                 w_end_st = ST_DOSE_LBL;
            PH_DOSE_LEAD:                w_end_st = ST_NO_DOSE;
            PH_DOSE_INT, PH_DOSE_FRAC:   w_end_st = r_digit ? ST_TAIL : ST_NO_DOSE;
            PH_TAIL_LIT:                 w_end_st = ST_TAIL;
            PH_MODE:                     w_end_st = ST_OK;
            default:                     w_end_st = r_err;
        endcase
    end

    // Next state for one byte
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_digit     = r_digit;
        n_neg       = r_neg;
        n_frac      = r_frac;
        n_cps       = r_cps;
        n_cpm       = r_cpm;
        n_dose      = r_dose;
        n_err       = r_err;
        n_len       = r_len;
        w_do_match  = 1'b0;
        o_res_valid = 1'b0;
        o_res.status     = w_end_st;
        o_res.cps_value  = (w_end_st == ST_OK) ? r_cps : 32'd0;
        o_res.cpm_value  = (w_end_st == ST_OK) ? r_cpm : 32'd0;
        o_res.dose_milli = (w_end_st == ST_OK) ? r_dose : 32'd0;

        if (w_step && i_byte == CHAR_NL) begin
            // Emit the result and clear the line
            o_res_valid = 1'b1;
            n_phase = PH_PREFIX;
            n_pos   = 4'd0;
            n_digit = 1'b0;
            n_neg   = 1'b0;
            n_frac  = 2'd0;
            n_cps   = 32'd0;
            n_cpm   = 32'd0;
            n_dose  = 32'd0;
            n_err   = ST_OK;
            n_len   = '0;
        end else if (w_step) begin
            if (r_len <= LEN_W'(LINE_MAX)) begin
                n_len = r_len + 1'b1;
            end
            if (n_len > LEN_W'(LINE_MAX)) begin
                n_err   = ST_OVERFLOW;
                n_phase = PH_SKIP;
            end else begin
                case (r_phase)
                    PH_PREFIX, PH_CPM_LIT, PH_DOSE_LIT, PH_TAIL_LIT: begin
                        w_do_match = 1'b1;
                    end
                    PH_CPS_LEAD, PH_CPM_LEAD: begin
                        if (w_sign) begin
                            n_neg   = (i_byte == "-");
                            n_phase = r_phase + 4'd1;
                        end else if (w_is_digit) begin
                            n_phase = r_phase + 4'd1;
                            n_digit = 1'b1;
                            if (r_phase == PH_CPS_LEAD) begin
                                n_cps = w_acc_dig;
                            end else begin
                                n_cpm = w_acc_dig;
                            end
                        end else if (!w_space) begin
                            n_err   = (r_phase == PH_CPS_LEAD) ? ST_NO_CPS : ST_NO_CPM;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_CPS_NUM, PH_CPM_NUM: begin
                        if (w_is_digit) begin
                            n_digit = 1'b1;
                            if (r_phase == PH_CPS_NUM) begin
                                n_cps = w_acc_dig;
                            end else begin
                                n_cpm = w_acc_dig;
                            end
                        end else if (!r_digit) begin
                            n_err   = (r_phase == PH_CPS_NUM) ? ST_NO_CPS : ST_NO_CPM;
                            n_phase = PH_SKIP;
                        end else begin
                            // Number ends: sign it and start the next literal
                            if (r_phase == PH_CPS_NUM) begin
                                n_cps = w_acc_end;
                            end else begin
                                n_cpm = w_acc_end;
                            end
                            n_phase    = r_phase + 4'd1;
                            w_do_match = 1'b1;
                        end
                    end
                    PH_DOSE_LEAD: begin
                        if (w_sign) begin
                            n_neg   = (i_byte == "-");
                            n_phase = PH_DOSE_INT;
                        end else if (w_is_digit) begin
                            n_phase = PH_DOSE_INT;
                            n_digit = 1'b1;
                            n_dose  = w_acc_dig;
                        end else if (i_byte == ".") begin
                            n_phase = PH_DOSE_FRAC;
                        end else if (!w_space) begin
                            n_err   = ST_NO_DOSE;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_DOSE_INT, PH_DOSE_FRAC: begin
                        if (w_is_digit) begin
                            n_digit = 1'b1;
                            if (r_phase == PH_DOSE_INT) begin
                                n_dose = w_acc_dig;
                            end else if (r_frac != 2'd3) begin
                                n_dose = w_acc_dig;
                                n_frac = r_frac + 2'd1;
                            end
                        end else if (i_byte == "." && r_phase == PH_DOSE_INT) begin
                            n_phase = PH_DOSE_FRAC;
                        end else if (!r_digit) begin
                            n_err   = ST_NO_DOSE;
                            n_phase = PH_SKIP;
                        end else begin
                            n_dose     = w_dose_end;
                            n_phase    = PH_TAIL_LIT;
                            w_do_match = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                // Advance through the literal or latch its error
                if (w_do_match) begin
                    if (w_hit) begin
                        n_pos = w_done ? 4'd0 : (w_pos_eff + 4'd1);
                        if (w_done) begin
                            n_phase = w_next;
                            n_digit = 1'b0;
                            n_neg   = 1'b0;
                            n_frac  = 2'd0;
                        end
                    end else begin
                        n_err   = w_code;
                        n_phase = PH_SKIP;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pos   <= 4'd0;
            r_digit <= 1'b0;
            r_neg   <= 1'b0;
            r_frac  <= 2'd0;
            r_cps   <= 32'd0;
            r_cpm   <= 32'd0;
            r_dose  <= 32'd0;
            r_err   <= ST_OK;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_digit <= n_digit;
            r_neg   <= n_neg;
            r_frac  <= n_frac;
            r_cps   <= n_cps;
            r_cpm   <= n_cpm;
            r_dose  <= n_dose;
            r_err   <= n_err;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rrlp_out_stage.sv
// Result register of the report line parser: holds one line result.
// Depends on rrlp_pkg.
`default_nettype none

module rrlp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire rrlp_pkg::t_result i_res,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rrlp_pkg::t_result      o_res
);
    import rrlp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Room when empty or the held result leaves this cycle
    assign o_room = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: hdl/radiation_report_line_parser.sv
// Top level of the report line parser: input register, parser, result register.
// Depends on rrlp_pkg, rrlp_in_stage, rrlp_parser and rrlp_out_stage.
//
// The block takes one character per beat and can accept a beat in every cycle.
// Each byte is first held in the input register. From there it updates the
// parser state and, for a newline, loads the result register, so a line result
// is on the output in the cycle after the parser takes its newline. Ordinary
// bytes are taken even while a result waits. The input stalls only when a
// newline is held and the result register is full and not being read in that
// cycle. A result holds status (0 ok, 1 to 7 the first element that failed, 8 a
// line longer than LINE_MAX bytes), and counts per second, counts per minute
// and dose in thousandths, all zero unless the status is ok.
`default_nettype none

module radiation_report_line_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata    // [3:0] status, [35:4] cps_value,
                                              // [67:36] cpm_value, [99:68] dose_milli
);
    import rrlp_pkg::*;

    logic       w_byte_valid;
    logic [7:0] w_byte;
    logic       w_take;
    logic       w_room;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    rrlp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (w_byte_valid),
        .o_byte  (w_byte),
        .i_take  (w_take)
    );

    rrlp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_byte_valid),
        .i_byte       (w_byte),
        .i_room       (w_room),
        .o_take       (w_take),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    rrlp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out)
    );

    // Pack the result beat
    assign m_axis_tdata = {4'd0, w_out};

`ifndef NO_ASSERTIONS
    // Failed lines carry zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.status != ST_OK) |->
        (w_out.cps_value == 32'sd0 && w_out.cpm_value == 32'sd0
         && w_out.dose_milli == 32'sd0))
        else $error("failed line with nonzero values");

    // Status stays within its codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out.status <= ST_OVERFLOW))
        else $error("status out of range");

    // A result appears only after a newline was parsed
    a_rise_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_take && w_byte == CHAR_NL))
        else $error("result without newline");

    // Input stalls only behind a newline that cannot be delivered
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |->
        (w_byte_valid && w_byte == CHAR_NL && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

// File: test/rrlp_line_checker.sv
`timescale 1ns / 100ps
// Line checker for the report line parser: follows the parse state per input beat,
// queues the expected line results and compares every result beat against them.
// Depends on rrlp_pkg for the result layout, LINE_MAX, CHAR_NL and status codes.

module rrlp_line_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [7:0]   i_in_data,     // [7:0] in_byte
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [103:0] i_out_data,    // [3:0] status, [35:4] cps_value,
                                             // [67:36] cpm_value, [99:68] dose_milli
    output int                o_fail_count,
    output int                o_open_count
);

    import rrlp_pkg::*;

    // Characters the line grammar cares about
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        S_HEAD, S_CPS_PAD, S_CPS_DIG, S_CPM_TAG, S_CPM_PAD, S_CPM_DIG,
        S_DOSE_TAG, S_DOSE_PAD, S_DOSE_WHOLE, S_DOSE_PART, S_SEP, S_MODE, S_DRAIN
    } t_parse_st;

    typedef enum logic [1:0] {TAG_HEAD, TAG_CPM, TAG_DOSE, TAG_SEP} t_tag;

    t_parse_st   parse_st;
    int          tag_idx;
    bit          have_digit;
    bit          is_neg;
    int          part_cnt;
    logic [31:0] cps_mag;
    logic [31:0] cpm_mag;
    logic [31:0] dose_mag;
    logic [3:0]  err_st;
    int          line_cnt;

    t_result     line_results_q[$];
    int          fail_cnt;

    function automatic int tag_len(input t_tag tag);
        case (tag)
            TAG_HEAD: return 5;
            TAG_CPM:  return 7;
            TAG_DOSE: return 10;
            default:  return 2;
        endcase
    endfunction

    // Literal text is right-aligned in the vector, first character highest
    function automatic logic [7:0] tag_char(input t_tag tag, input int pos);
        logic [79:0] txt;
        case (tag)
            TAG_HEAD: txt = "CPS, ";
            TAG_CPM:  txt = ", CPM, ";
            TAG_DOSE: txt = ", uSv/hr, ";
            default:  txt = ", ";
        endcase
        return txt[8 * (tag_len(tag) - 1 - pos) +: 8];
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Multiply-by-ten add, clamped at the largest negative magnitude
    function automatic logic [31:0] mac10(input logic [31:0] acc, input logic [3:0] d);
        logic [63:0] v;
        v = {32'd0, acc} * 64'd10 + {60'd0, d};
        return (v > {32'd0, MAG_LIMIT}) ? MAG_LIMIT : v[31:0];
    endfunction

    function automatic logic [31:0] signed_of(input logic [31:0] mag);
        if (is_neg) begin
            return 32'd0 - mag;
        end
        return (mag > POS_LIMIT) ? POS_LIMIT : mag;
    endfunction

    task automatic clear_line();
        parse_st   = S_HEAD;
        tag_idx    = 0;
        have_digit = 1'b0;
        is_neg     = 1'b0;
        part_cnt   = 0;
        cps_mag    = '0;
        cpm_mag    = '0;
        dose_mag   = '0;
        err_st     = ST_OK;
        line_cnt   = 0;
    endtask

    // Latch the first error and skip the rest of the line
    task automatic abort(input logic [3:0] code);
        err_st   = code;
        parse_st = S_DRAIN;
    endtask

    task automatic open_number(input t_parse_st nxt);
        parse_st   = nxt;
        have_digit = 1'b0;
        is_neg     = 1'b0;
        part_cnt   = 0;
    endtask

    task automatic match_tag(input t_tag tag, input logic [7:0] c, input logic [3:0] code,
                             input t_parse_st nxt);
        if (tag_idx < tag_len(tag) && c == tag_char(tag, tag_idx)) begin
            tag_idx++;
            if (tag_idx == tag_len(tag)) begin
                tag_idx = 0;
                open_number(nxt);
            end
        end else begin
            abort(code);
        end
    endtask

    // Blanks and one sign before an integer; the digit value is the low nibble
    task automatic int_pad(input logic [7:0] c, input bit cpm);
        if (!is_blank(c)) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
                is_neg   = (c == CH_MINUS);
                parse_st = cpm ? S_CPM_DIG : S_CPS_DIG;
            end else if (is_num(c)) begin
                parse_st   = cpm ? S_CPM_DIG : S_CPS_DIG;
                have_digit = 1'b1;
                if (cpm) cpm_mag = mac10(cpm_mag, c[3:0]);
                else     cps_mag = mac10(cps_mag, c[3:0]);
            end else begin
                abort(cpm ? ST_NO_CPM : ST_NO_CPS);
            end
        end
    endtask

    // Digits of an integer; the first other byte closes it and starts the next label
    task automatic int_digits(input logic [7:0] c, input bit cpm);
        if (is_num(c)) begin
            have_digit = 1'b1;
            if (cpm) cpm_mag = mac10(cpm_mag, c[3:0]);
            else     cps_mag = mac10(cps_mag, c[3:0]);
        end else if (!have_digit) begin
            abort(cpm ? ST_NO_CPM : ST_NO_CPS);
        end else begin
            tag_idx = 0;
            if (cpm) begin
                cpm_mag  = signed_of(cpm_mag);
                parse_st = S_DOSE_TAG;
                match_tag(TAG_DOSE, c, ST_DOSE_LBL, S_DOSE_PAD);
            end else begin
                cps_mag  = signed_of(cps_mag);
                parse_st = S_CPM_TAG;
                match_tag(TAG_CPM, c, ST_CPM_LABEL, S_CPM_PAD);
            end
        end
    endtask

    // Dose digits, keeping at most three fraction digits
    task automatic dose_step(input logic [7:0] c);
        int k;
        if (is_num(c)) begin
            have_digit = 1'b1;
            if (parse_st == S_DOSE_WHOLE) begin
                dose_mag = mac10(dose_mag, c[3:0]);
            end else if (part_cnt < 3) begin
                dose_mag = mac10(dose_mag, c[3:0]);
                part_cnt++;
            end
        end else if (c == CH_DOT && parse_st == S_DOSE_WHOLE) begin
            parse_st = S_DOSE_PART;
        end else if (!have_digit) begin
            abort(ST_NO_DOSE);
        end else begin
            for (k = part_cnt; k < 3; k++) dose_mag = mac10(dose_mag, 4'd0);
            dose_mag = signed_of(dose_mag);
            parse_st = S_SEP;
            tag_idx  = 0;
            match_tag(TAG_SEP, c, ST_TAIL, S_MODE);
        end
    endtask

    // Status of a line that ends in the current state
    function automatic logic [3:0] line_status();
        case (parse_st)
            S_HEAD:                    return ST_PREFIX;
            S_CPS_PAD:                 return ST_NO_CPS;
            S_CPS_DIG:                 return have_digit ? ST_CPM_LABEL : ST_NO_CPS;
            S_CPM_TAG:                 return ST_CPM_LABEL;
            S_CPM_PAD:                 return ST_NO_CPM;
            S_CPM_DIG:                 return have_digit ? ST_DOSE_LBL : ST_NO_CPM;
            S_DOSE_TAG:                return ST_DOSE_LBL;
            S_DOSE_PAD:                return ST_NO_DOSE;
            S_DOSE_WHOLE, S_DOSE_PART: return have_digit ? ST_TAIL : ST_NO_DOSE;
            S_SEP:                     return ST_TAIL;
            S_MODE:                    return ST_OK;
            default:                   return err_st;
        endcase
    endfunction

    task automatic predict_byte(input logic [7:0] c, output bit done, output t_result res);
        done = 1'b0;
        res  = '0;
        if (c == CHAR_NL) begin
            done       = 1'b1;
            res.status = line_status();
            if (res.status == ST_OK) begin
                res.cps_value  = cps_mag;
                res.cpm_value  = cpm_mag;
                res.dose_milli = dose_mag;
            end
            clear_line();
        end else begin
            if (line_cnt <= LINE_MAX) line_cnt++;
            if (line_cnt > LINE_MAX) begin
                abort(ST_OVERFLOW);
            end else begin
                case (parse_st)
                    S_HEAD:     match_tag(TAG_HEAD, c, ST_PREFIX, S_CPS_PAD);
                    S_CPS_PAD:  int_pad(c, 1'b0);
                    S_CPS_DIG:  int_digits(c, 1'b0);
                    S_CPM_TAG:  match_tag(TAG_CPM, c, ST_CPM_LABEL, S_CPM_PAD);
                    S_CPM_PAD:  int_pad(c, 1'b1);
                    S_CPM_DIG:  int_digits(c, 1'b1);
                    S_DOSE_TAG: match_tag(TAG_DOSE, c, ST_DOSE_LBL, S_DOSE_PAD);
                    S_DOSE_PAD: begin
                        if (!is_blank(c)) begin
                            if (c == CH_PLUS || c == CH_MINUS) begin
                                is_neg   = (c == CH_MINUS);
                                parse_st = S_DOSE_WHOLE;
                            end else if (is_num(c) || c == CH_DOT) begin
                                parse_st = S_DOSE_WHOLE;
                                dose_step(c);
                            end else begin
                                abort(ST_NO_DOSE);
                            end
                        end
                    end
                    S_DOSE_WHOLE, S_DOSE_PART: dose_step(c);
                    S_SEP:      match_tag(TAG_SEP, c, ST_TAIL, S_MODE);
                    default: begin
                        // mode text and skipped bytes change nothing
                    end
                endcase
            end
        end
    endtask

    // Compare one result beat with the oldest pending line result
    task automatic check_result(input logic [103:0] data);
        t_result got;
        t_result want;
        got = data[99:0];
        if (line_results_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("result beat with no line pending: %s %0d cps %0d cpm %0d dose %0d",
                         "status", got.status, got.cps_value, got.cpm_value,
                         got.dose_milli);
        end else begin
            want = line_results_q.pop_front();
            if (got.status !== want.status || got.cps_value !== want.cps_value ||
                got.cpm_value !== want.cpm_value || got.dose_milli !== want.dose_milli) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display({"line result mismatch (expected/actual): ",
                              "status %0d/%0d cps %0d/%0d cpm %0d/%0d dose %0d/%0d"},
                             want.status, got.status, want.cps_value, got.cps_value,
                             want.cpm_value, got.cpm_value, want.dose_milli,
                             got.dose_milli);
            end
        end
    endtask

    initial begin
        fail_cnt = 0;
        clear_line();
    end

    // Watch both channels; result beats first, a newline beat can not return this cycle
    always @(posedge i_clk) begin : watch
        bit      done;
        t_result res;
        if (!i_rst_n) begin
            clear_line();
        end else begin
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) check_result(i_out_data);
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                predict_byte(i_in_data, done, res);
                if (done) line_results_q.push_back(res);
            end
        end
        o_fail_count <= fail_cnt;
        o_open_count <= line_results_q.size();
    end

endmodule

// File: test/radiation_report_line_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for the report line parser: clock, reset, byte and result handshakes.
// Depends on rrlp_pkg, radiation_report_line_parser and rrlp_line_checker.

module radiation_report_line_parser_tb;

    import rrlp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int BYTES_MIN   = 1300;
    localparam int LINES_MIN   = 24;

    logic           i_clk;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [103:0]   m_axis_tdata;            // [3:0] status, [35:4] cps_value,
                                             // [67:36] cpm_value, [99:68] dose_milli
    int             fail_count;
    int             open_count;
    int             cycle_cnt     = 0;
    bit             tx_fast       = 1'b0;
    int             bytes_sent    = 0;
    int             lines_sent    = 0;
    logic [7:0]     line_buf[$];

    radiation_report_line_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rrlp_line_checker u_line_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL radiation_report_line_parser");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each beat, with fast stretches
    initial begin : result_sink
        int stall;
        int left;
        bit fast;
        left = 0;
        fast = 1'b0;
        forever begin
            if (left == 0) begin
                fast = ($urandom_range(0, 3) == 0);
                left = $urandom_range(4, 12);
            end
            left--;
            stall = fast ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) put_byte(line_buf[i]);
        bytes_sent += line_buf.size();
        lines_sent++;
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        logic [7:0] d;
        for (int i = 0; i < n; i++) begin
            d = 8'($urandom_range(0, 9));
            line_buf.push_back("0" + d);
        end
    endtask

    // Optional blanks (space, tab, vertical tab, form feed, return) and a sign
    task automatic add_lead();
        int n;
        int r;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0:       line_buf.push_back(8'd32);
                1:       line_buf.push_back(8'd9);
                2:       line_buf.push_back(8'd11);
                3:       line_buf.push_back(8'd12);
                default: line_buf.push_back(8'd13);
            endcase
        end
        r = $urandom_range(0, 5);
        if (r == 0) push_text("+");
        else if (r == 1) push_text("-");
    endtask

    // Integer count, now and then at or past the 32-bit bounds
    task automatic add_count();
        add_lead();
        case ($urandom_range(0, 19))
            0:       push_text("2147483648");
            1:       push_text("2147483647");
            2, 3:    add_digits($urandom_range(10, 13));
            default: add_digits($urandom_range(1, 4));
        endcase
    endtask

    task automatic add_dose();
        add_lead();
        case ($urandom_range(0, 9))
            0: add_digits($urandom_range(1, 3));
            1: begin
                push_text(".");
                add_digits($urandom_range(1, 5));
            end
            2: begin
                add_digits($urandom_range(1, 2));
                push_text(".");
            end
            3: begin
                push_text("2147484");
                add_digits($urandom_range(0, 3));
            end
            default: begin
                add_digits($urandom_range(1, 2));
                push_text(".");
                add_digits($urandom_range(1, 4));
            end
        endcase
    endtask

    // Well-formed report without its newline
    task automatic build_report();
        logic [7:0] b;
        int         r;
        push_text("CPS, ");
        add_count();
        push_text(", CPM, ");
        add_count();
        push_text(", uSv/hr, ");
        add_dose();
        push_text(", ");
        r = $urandom_range(0, 4);
        if (r == 0) begin
            // no mode text
        end else if (r == 1) begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
                do b = 8'($urandom_range(0, 255)); while (b == CHAR_NL);
                line_buf.push_back(b);
            end
        end else if (r == 2) begin
            push_text("SLOW");
        end else if (r == 3) begin
            push_text("FAST");
        end else begin
            push_text("INST");
        end
    endtask

    initial begin : stimulus
        int         kind;
        int         k;
        int         tgt;
        logic [7:0] b;
        string      near_chars;
        near_chars = ",. +-0e9";

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty line, missing count, bad prefix with bit 7 set, zero byte, bare sign
        push_text("\n");
        push_text("CPS, \n");
        push_text("C");
        line_buf.push_back(8'hFF);
        line_buf.push_back(CHAR_NL);
        line_buf.push_back(8'h00);
        line_buf.push_back(CHAR_NL);
        push_text("CPS, -\n");
        send_line();

        // Mostly reports with random content; the rest broken, cut, overlong or noise
        while (bytes_sent < BYTES_MIN || lines_sent < LINES_MIN) begin
            tx_fast = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 94) build_report();
            if (kind < 60) begin
                line_buf.push_back(CHAR_NL);
            end else if (kind < 80) begin
                k = $urandom_range(0, line_buf.size() - 1);
                if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 255));
                else b = near_chars[$urandom_range(0, 7)];
                line_buf[k] = b;
                line_buf.push_back(CHAR_NL);
            end else if (kind < 88) begin
                k = $urandom_range(0, line_buf.size() - 1);
                while (line_buf.size() > k) line_buf.delete(line_buf.size() - 1);
                line_buf.push_back(CHAR_NL);
            end else if (kind < 94) begin
                // pad around the length limit, or well past it
                if ($urandom_range(0, 1) == 0) tgt = LINE_MAX - 1 + $urandom_range(0, 2);
                else tgt = LINE_MAX + $urandom_range(1, 30);
                while (line_buf.size() < tgt) push_text("x");
                line_buf.push_back(CHAR_NL);
            end else begin
                for (k = $urandom_range(0, 16); k > 0; k--) begin
                    b = 8'($urandom_range(0, 255));
                    line_buf.push_back(b);
                end
                line_buf.push_back(CHAR_NL);
            end
            send_line();
        end
        s_axis_tvalid <= 1'b0;

        // Drain pending results, then wait for stray beats
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS radiation_report_line_parser");
        end else begin
            $display("FAIL radiation_report_line_parser");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/rrlp_pkg.sv
hdl/rrlp_in_stage.sv
hdl/rrlp_parser.sv
hdl/rrlp_out_stage.sv
hdl/radiation_report_line_parser.sv
test/rrlp_line_checker.sv
test/radiation_report_line_parser_tb.sv
